### design/bfpa_pkg.sv
// Shared field widths, op codes and status codes for the best-fit partition allocator.
package bfpa_pkg;

  // Payload field widths
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 5;

  // Request op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // One result as held before it is offered downstream
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   block_index;
    logic [SIZE_W-1:0]   block_size;
    logic [SIZE_W-1:0]   leftover;
  } result_t;

endpackage

### design/bfpa_if.sv
// Valid/ready channel interfaces for allocator requests and results.
interface bfpa_in_if import bfpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SIZE_W-1:0] size;

  modport source (output valid, output op, output size, input ready);
  modport sink   (input valid, input op, input size, output ready);
endinterface

interface bfpa_out_if import bfpa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0]   block_index;
  logic [SIZE_W-1:0]   block_size;
  logic [SIZE_W-1:0]   leftover;

  modport source (output valid, output status, output block_index, output block_size,
                  output leftover, input ready);
  modport sink   (input valid, input status, input block_index, input block_size,
                  input leftover, output ready);
endinterface

### design/best_fit_partition_allocator_core.sv
// Best-fit partition allocator: a load or clear request passes through S_FIN to a registered
// result, and the next request is taken only once the block is back in S_IDLE; an allocate request
// scans the table one entry a cycle through the single memory read port and the shared fit
// unit, then passes S_DRAIN, S_COMMIT and S_FIN before its result and the next acceptance
// (on an empty table it goes straight to S_FIN). Output stalls hold S_FIN. Synchronous
// active-low reset empties the table and clears the output; table memory is not reset.
module best_fit_partition_allocator_core import bfpa_pkg::*; #(
  parameter int BLOCKS    = 32,
  parameter int SIZE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  bfpa_in_if.sink       in_ch,
  bfpa_out_if.source    out_ch
);

  localparam int IDX_W  = $clog2(BLOCKS);
  localparam int CNT_W  = $clog2(BLOCKS + 1);
  localparam int WORD_W = SIZE_BITS + 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_FIN} state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     scan_idx_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [SIZE_BITS-1:0] best_left_r;
  logic [SIZE_BITS-1:0] best_size_r;
  logic [SIZE_BITS-1:0] req_r;
  result_t              res_r;
  logic                 out_valid_r;
  result_t              out_r;

  logic                         in_fire;
  logic                         full;
  logic                         last_issue;
  logic [SIZE_BITS+SIZE_W-1:0]  req_ext;
  logic [SIZE_BITS-1:0]         req_in;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [WORD_W-1:0]            mem_wdata;
  logic                         mem_re;
  logic [WORD_W-1:0]            mem_rdata;
  logic                         fit_better;
  logic [SIZE_BITS-1:0]         fit_left;

  // zero-extend or truncate a table index to the result index field
  function automatic logic [BIDX_W-1:0] to_bidx(input logic [IDX_W-1:0] i);
    logic [IDX_W+BIDX_W-1:0] w;
    w = {{BIDX_W{1'b0}}, i};
    return w[BIDX_W-1:0];
  endfunction

  // zero-extend or truncate a stored size to the 16-bit result fields
  function automatic logic [SIZE_W-1:0] to_size16(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS+SIZE_W-1:0] w;
    w = {{SIZE_W{1'b0}}, s};
    return w[SIZE_W-1:0];
  endfunction

  // handshake and request decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign full        = (count_r == CNT_W'(BLOCKS));
  assign req_ext     = {{SIZE_BITS{1'b0}}, in_ch.size};
  assign req_in      = req_ext[SIZE_BITS-1:0];
  assign last_issue  = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);

  // memory port control: loads write a free entry, commit marks the winner taken
  assign mem_we    = (in_fire && (in_ch.op == OP_LOAD) && !full) ||
                     ((state_r == S_COMMIT) && found_r);
  assign mem_waddr = (state_r == S_COMMIT) ? best_idx_r : count_r[IDX_W-1:0];
  assign mem_wdata = (state_r == S_COMMIT) ? {1'b1, best_size_r} : {1'b0, req_in};
  assign mem_re    = (state_r == S_SCAN);

  bfpa_mem #(
    .DEPTH  (BLOCKS),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_idx_r),
    .rdata (mem_rdata)
  );

  bfpa_fit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .entry_taken (mem_rdata[WORD_W-1]),
    .entry_size  (mem_rdata[SIZE_BITS-1:0]),
    .req         (req_r),
    .found       (found_r),
    .best_left   (best_left_r),
    .better      (fit_better),
    .left        (fit_left)
  );

  // output channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.block_index = out_r.block_index;
  assign out_ch.block_size  = out_r.block_size;
  assign out_ch.leftover    = out_r.leftover;

  // sequencer, scan bookkeeping and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // read data pipeline tag
      rd_vld_r <= (state_r == S_SCAN);
      rd_idx_r <= scan_idx_r;

      // track the best candidate as entries come back from memory
      if (rd_vld_r && fit_better) begin
        found_r     <= 1'b1;
        best_idx_r  <= rd_idx_r;
        best_left_r <= fit_left;
        best_size_r <= mem_rdata[SIZE_BITS-1:0];
      end

      // result taken downstream; a waiting result reloads the register in S_FIN
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r <= req_in;
            case (in_ch.op)
              OP_LOAD: begin
                state_r <= S_FIN;
                if (full) begin
                  res_r <= '{status: ST_FULL, block_index: '0, block_size: '0, leftover: '0};
                end else begin
                  res_r   <= '{status:      ST_OK,
                               block_index: to_bidx(count_r[IDX_W-1:0]),
                               block_size:  '0,
                               leftover:    '0};
                  count_r <= count_r + CNT_W'(1);
                end
              end
              OP_ALLOC: begin
                found_r    <= 1'b0;
                scan_idx_r <= '0;
                if (count_r == '0) begin
                  res_r   <= '{status: ST_NOFIT, block_index: '0, block_size: '0, leftover: '0};
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              OP_CLEAR: begin
                // new loads rewrite the taken mark, so dropping the count empties the table
                count_r <= '0;
                res_r   <= '{status: ST_OK, block_index: '0, block_size: '0, leftover: '0};
                state_r <= S_FIN;
              end
              default: begin
                res_r   <= '{status: ST_OK, block_index: '0, block_size: '0, leftover: '0};
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
          if (last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (found_r) begin
            res_r <= '{status:      ST_ALLOC,
                       block_index: to_bidx(best_idx_r),
                       block_size:  to_size16(best_size_r),
                       leftover:    to_size16(best_left_r)};
          end else begin
            res_r <= '{status: ST_NOFIT, block_index: '0, block_size: '0, leftover: '0};
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_r       <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/bfpa_mem.sv
// Partition table memory: one write port, one read port with registered data.
module bfpa_mem #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 17,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### design/bfpa_fit.sv
// Shared fit unit: leftover subtract and best-so-far compare for one table entry.
module bfpa_fit #(
  parameter int SIZE_BITS = 16
) (
  input  logic                 entry_taken,
  input  logic [SIZE_BITS-1:0] entry_size,
  input  logic [SIZE_BITS-1:0] req,
  input  logic                 found,
  input  logic [SIZE_BITS-1:0] best_left,
  output logic                 better,
  output logic [SIZE_BITS-1:0] left
);

  logic fits;

  // entry must be free and large enough; strict compare keeps the lowest index on ties
  assign left   = entry_size - req;
  assign fits   = !entry_taken && (entry_size >= req);
  assign better = fits && (!found || (left < best_left));

endmodule

### test/tb.sv
// Self-checking testbench for the best-fit partition allocator core.
`timescale 1ns / 1ps

module tb import bfpa_pkg::*;;

  localparam int BLOCKS         = 32;
  localparam int SIZE_BITS      = 16;
  localparam int REQUEST_TARGET = 1230;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 50;

  // op value the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  bfpa_in_if  in_ch ();
  bfpa_out_if out_ch ();

  best_fit_partition_allocator_core #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the partition table
  logic [SIZE_W-1:0] tbl_size [BLOCKS];
  logic [BLOCKS-1:0] tbl_taken;
  int                tbl_count;

  result_t           pending_outcomes[$];
  logic [SIZE_W-1:0] loaded_sizes[$];
  int                requests_sent;
  int                results_checked;
  int                mismatches;
  int                idle_cycles;
  int                stall_left;
  int                calm_left;
  bit                sender_calm;

  // Outcome of one request; updates the shadow table
  function automatic result_t best_fit_outcome(logic [OP_W-1:0] op, logic [SIZE_W-1:0] req);
    result_t           r;
    bit                found;
    int                best;
    logic [SIZE_W-1:0] best_left;
    r         = '0;
    found     = 1'b0;
    best      = 0;
    best_left = '0;
    case (op)
      OP_LOAD: begin
        if (tbl_count >= BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          tbl_size[tbl_count]  = req;
          tbl_taken[tbl_count] = 1'b0;
          r.status             = ST_OK;
          r.block_index        = BIDX_W'(tbl_count);
          tbl_count++;
        end
      end
      OP_ALLOC: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_taken[i] && tbl_size[i] >= req) begin
            if (!found || (tbl_size[i] - req) < best_left) begin
              found     = 1'b1;
              best      = i;
              best_left = tbl_size[i] - req;
            end
          end
        end
        if (found) begin
          tbl_taken[best] = 1'b1;
          r.status        = ST_ALLOC;
          r.block_index   = BIDX_W'(best);
          r.block_size    = tbl_size[best];
          r.leftover      = best_left;
        end else begin
          r.status = ST_NOFIT;
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_taken = '0;
        r.status  = ST_OK;
      end
      default: r.status = ST_OK;
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [SIZE_W-1:0] size_in_mode(int mode);
    case (mode)
      0:       return SIZE_W'($urandom_range(0, 15));
      1:       return SIZE_W'($urandom_range(0, 1023));
      default: return SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Request size close to a loaded one, so exact fits and ties turn up
  function automatic logic [SIZE_W-1:0] near_request(int mode);
    logic [SIZE_W-1:0] base;
    int                delta;
    if (loaded_sizes.size() == 0 || $urandom_range(0, 2) == 0) return size_in_mode(mode);
    base  = loaded_sizes[$urandom_range(0, loaded_sizes.size() - 1)];
    delta = $urandom_range(0, 4);
    case ($urandom_range(0, 2))
      0:       return base;
      1:       return (base > delta) ? base - SIZE_W'(delta) : '0;
      default: return base + 1'b1;
    endcase
  endfunction

  // Send one request; returns at the edge where it was accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz);
    int gap;
    gap = sender_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.size  <= sz;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // Stop offering requests and wait until every result is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (results_checked != requests_sent) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: random stalls with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) < 5) calm_left = $urandom_range(40, 200);
      else stall_left = idle_gap();
    end
  end

  // Result check, prediction of accepted requests and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, status %0d", $time,
                   out_ch.status);
        end else begin
          result_t e;
          e = pending_outcomes.pop_front();
          report_field("status", e.status, out_ch.status);
          report_field("block_index", e.block_index, out_ch.block_index);
          report_field("block_size", e.block_size, out_ch.block_size);
          report_field("leftover", e.leftover, out_ch.leftover);
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_outcomes.push_back(best_fit_outcome(in_ch.op, in_ch.size));
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Empty table: allocate finds nothing, unused op and clear do nothing
  task automatic test_empty_table();
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_UNUSED, 16'hFFFF);
    send_request(OP_CLEAR, 16'hFFFF);
  endtask

  // Best fit, tie to lowest index, extremes of size, all taken
  task automatic test_best_fit();
    send_request(OP_LOAD, 16'd0);
    send_request(OP_LOAD, 16'hFFFF);
    send_request(OP_LOAD, 16'd100);
    send_request(OP_LOAD, 16'd100);
    send_request(OP_LOAD, 16'd50);
    send_request(OP_ALLOC, 16'd40);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_ALLOC, 16'd100);
    send_request(OP_ALLOC, 16'd100);
    send_request(OP_ALLOC, 16'd101);
    send_request(OP_ALLOC, 16'd0);
    send_request(OP_UNUSED, 16'h5555);
    send_request(OP_CLEAR, 16'h0000);
  endtask

  // Table reused after a clear starts again at index zero
  task automatic test_clear_reuse();
    send_request(OP_LOAD, 16'd7);
    send_request(OP_ALLOC, 16'd7);
  endtask

  // Fill the table, drain, then overflow it and allocate from it
  task automatic test_full_table();
    logic [SIZE_W-1:0] v;
    send_request(OP_CLEAR, 16'h0000);
    loaded_sizes.delete();
    repeat (BLOCKS) begin
      v = size_in_mode(2);
      loaded_sizes.push_back(v);
      send_request(OP_LOAD, v);
    end
    wait_for_results();
    send_request(OP_LOAD, 16'hFFFF);
    send_request(OP_LOAD, 16'h0000);
    repeat (8) send_request(OP_ALLOC, near_request(2));
    repeat (4) send_request(OP_ALLOC, 16'h0000);
  endtask

  // Random sessions: mostly clear, load, allocate, with some noise mixed in
  task automatic test_random_sessions();
    int                mode;
    int                n_loads;
    int                n_allocs;
    int                pick;
    logic [SIZE_W-1:0] v;
    while (requests_sent < REQUEST_TARGET) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      mode        = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 8) begin
        send_request(OP_CLEAR, SIZE_W'($urandom_range(0, 65535)));
        loaded_sizes.delete();
      end
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 20);
      repeat (n_loads) begin
        v = size_in_mode(mode);
        loaded_sizes.push_back(v);
        send_request(OP_LOAD, v);
      end
      n_allocs = $urandom_range(1, n_loads + 4);
      repeat (n_allocs) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_request(OP_UNUSED, SIZE_W'($urandom_range(0, 65535)));
        end else if (pick < 8) begin
          v = size_in_mode(mode);
          loaded_sizes.push_back(v);
          send_request(OP_LOAD, v);
        end else begin
          send_request(OP_ALLOC, near_request(mode));
        end
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    tbl_count       = 0;
    tbl_taken       = '0;
    requests_sent   = 0;
    results_checked = 0;
    mismatches      = 0;
    sender_calm     = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_LOAD;
    in_ch.size   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_best_fit();
    test_clear_reuse();
    test_full_table();
    test_random_sessions();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0t: %0d results still expected", $time, pending_outcomes.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
